FILE: design/tdh_pkg.sv
// Shared types, codes and default sizes for the token dictionary.
`timescale 1ns / 1ps

package tdh_pkg;

    // Default sizes
    localparam int NUM_BUCKETS_DEF  = 100;
    localparam int TOKEN_BYTES_DEF  = 32;
    localparam int BUCKET_DEPTH_DEF = 64;

    // Fixed field widths
    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ID_IN_W  = 16;
    localparam int ID_OUT_W = 13;
    localparam int STATUS_W = 3;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REV    = 2'd2,
        FUNC_NOP    = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_DUP       = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_TOO_LONG  = 3'd4
    } t_status;

    // Result beat source
    typedef enum logic [1:0] {
        RES_CODE = 2'd0,
        RES_HIT  = 2'd1,
        RES_BYTE = 2'd2
    } t_res_sel;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [CHAR_W-1:0]  token_char;
        logic               last_char;
        logic [ID_IN_W-1:0] id_in;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_OUT_W-1:0] id_out;
        logic [CHAR_W-1:0]   out_char;
        logic                last_result;
    } t_out_beat;

    // Controller to datapath commands
    typedef struct packed {
        logic     take_byte;
        logic     take_id;
        logic     div_fix;
        logic     rd_fill;
        logic     slot_clr;
        logic     slot_inc;
        logic     rev_slot;
        logic     rd_len;
        logic     k_clr;
        logic     k_inc;
        logic     rd_tok;
        logic     rd_asm;
        logic     wr_tok;
        logic     wr_meta;
        logic     clr_asm;
        logic     ld_out;
        t_res_sel res_sel;
        t_status  code;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic func_add;
        logic ovl;
        logic fill_lt;
        logic full;
        logic len_eq;
        logic byte_eq;
        logic k_last;
        logic rev_bad;
        logic rlen_bad;
        logic out_free;
    } t_sts;

endpackage

FILE: design/tdh_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module tdh_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write or read one word per cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/tdh_datapath.sv
// Datapath: token assembly, bucket hashing, stores, compare and result register.
`timescale 1ns / 1ps

module tdh_datapath #(
    parameter int NUM_BUCKETS  = tdh_pkg::NUM_BUCKETS_DEF,
    parameter int TOKEN_BYTES  = tdh_pkg::TOKEN_BYTES_DEF,
    parameter int BUCKET_DEPTH = tdh_pkg::BUCKET_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tdh_pkg::t_in_beat i_in,
    input  tdh_pkg::t_cmd     i_cmd,
    output tdh_pkg::t_sts     o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output tdh_pkg::t_out_beat o_out
);

    localparam int MAX_LEN  = TOKEN_BYTES - 1;
    localparam int BW       = $clog2(NUM_BUCKETS);
    localparam int SW       = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int KW       = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LW       = $clog2(TOKEN_BYTES);
    localparam int FW       = $clog2(BUCKET_DEPTH + 1);
    localparam int IW       = tdh_pkg::ID_IN_W;
    localparam int RECIP    = (1 << IW) / NUM_BUCKETS;
    localparam int RW       = $clog2(RECIP + 1);
    localparam int NBW      = $clog2(NUM_BUCKETS + 1);
    localparam int HW       = FW + 1 + NBW;
    localparam int TOK_DEPTH = NUM_BUCKETS << (SW + KW);
    localparam int LEN_DEPTH = NUM_BUCKETS << SW;

    // Assembly and request state
    logic [LW-1:0]  r_alen;
    logic [BW-1:0]  r_sum;
    logic           r_ovl;
    logic           r_func_add;
    logic           r_rev;
    logic [IW-1:0]  r_id;
    logic [IW-1:0]  r_q;
    logic [BW-1:0]  r_b;
    logic [FW-1:0]  r_slot;
    logic [LW-1:0]  r_k;
    logic           r_fill_vld;
    logic [NUM_BUCKETS-1:0] r_vld;
    logic           r_out_valid;
    tdh_pkg::t_out_beat r_out;

    logic [BW-1:0]  w_mod_tab [256];
    logic [BW:0]    w_sum_raw;
    logic [BW-1:0]  w_sum_mod;
    logic [IW+RW-1:0] w_qe_prod;
    logic [IW+NBW-1:0] w_qnb;
    logic [IW:0]    w_rem;
    logic           w_rem_ge;
    logic [FW-1:0]  w_fill_q;
    logic [FW-1:0]  w_fill_val;
    logic [LW-1:0]  w_len_q;
    logic [7:0]     w_tok_q;
    logic [7:0]     w_asm_q;
    logic [LW-1:0]  w_k_target;
    logic           w_k_last;
    logic [HW-1:0]  w_hit_id;
    logic           w_out_free;
    logic           w_asm_en;

    // Byte residue table
    for (genvar g = 0; g < 256; g++) begin : g_mod
        localparam int MV = g % NUM_BUCKETS;
        assign w_mod_tab[g] = BW'(MV);
    end

    // Running bucket: residue add with one correction
    assign w_sum_raw = {1'b0, r_sum} + {1'b0, w_mod_tab[i_in.token_char]};
    assign w_sum_mod = (w_sum_raw >= (BW+1)'(NUM_BUCKETS)) ?
                       BW'(w_sum_raw - (BW+1)'(NUM_BUCKETS)) : BW'(w_sum_raw);

    // Id split: reciprocal estimate, then one remainder correction
    assign w_qe_prod = IW'(i_in.id_in) * RW'(RECIP);
    assign w_qnb     = r_q * NBW'(NUM_BUCKETS);
    assign w_rem     = {1'b0, r_id} - (IW+1)'(w_qnb);
    assign w_rem_ge  = w_rem >= (IW+1)'(NUM_BUCKETS);

    // Stores
    assign w_asm_en = (i_cmd.take_byte && (r_alen < LW'(MAX_LEN))) || i_cmd.rd_asm;

    tdh_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_asm_ram (
        .i_clk   (i_clk),
        .i_en    (w_asm_en),
        .i_we    (i_cmd.take_byte),
        .i_addr  (i_cmd.take_byte ? r_alen[KW-1:0] : r_k[KW-1:0]),
        .i_wdata (i_in.token_char),
        .o_rdata (w_asm_q)
    );

    tdh_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_en    (i_cmd.rd_fill | i_cmd.wr_meta),
        .i_we    (i_cmd.wr_meta),
        .i_addr  (r_b),
        .i_wdata (FW'(w_fill_val + 1'b1)),
        .o_rdata (w_fill_q)
    );

    tdh_ram #(.WIDTH(LW), .DEPTH(LEN_DEPTH)) u_len_ram (
        .i_clk   (i_clk),
        .i_en    (i_cmd.rd_len | i_cmd.wr_meta),
        .i_we    (i_cmd.wr_meta),
        .i_addr  ({r_b, r_slot[SW-1:0]}),
        .i_wdata (r_alen),
        .o_rdata (w_len_q)
    );

    tdh_ram #(.WIDTH(8), .DEPTH(TOK_DEPTH)) u_tok_ram (
        .i_clk   (i_clk),
        .i_en    (i_cmd.rd_tok | i_cmd.wr_tok),
        .i_we    (i_cmd.wr_tok),
        .i_addr  ({r_b, r_slot[SW-1:0], r_k[KW-1:0]}),
        .i_wdata (w_asm_q),
        .o_rdata (w_tok_q)
    );

    // Unwritten buckets read as empty
    assign w_fill_val = r_fill_vld ? w_fill_q : '0;

    assign w_k_target = r_rev ? w_len_q : r_alen;
    assign w_k_last   = LW'(r_k + 1'b1) == w_k_target;
    assign w_hit_id   = (HW'(r_slot) + 1'b1) * HW'(NUM_BUCKETS) + HW'(r_b);
    assign w_out_free = !r_out_valid || i_out_ready;

    // Assembly state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alen <= '0;
            r_sum  <= '0;
            r_ovl  <= 1'b0;
        end else if (i_cmd.clr_asm) begin
            r_alen <= '0;
            r_sum  <= '0;
            r_ovl  <= 1'b0;
        end else if (i_cmd.take_byte) begin
            r_sum <= w_sum_mod;
            if (r_alen < LW'(MAX_LEN)) begin
                r_alen <= LW'(r_alen + 1'b1);
            end else begin
                r_ovl <= 1'b1;
            end
        end
    end

    // Bucket valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.wr_meta) begin
            r_vld[r_b] <= 1'b1;
        end
    end

    // Request registers and counters
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            r_func_add <= i_in.func == tdh_pkg::FUNC_ADD;
            r_rev      <= 1'b0;
            r_b        <= w_sum_mod;
        end
        if (i_cmd.take_id) begin
            r_rev <= 1'b1;
            r_id  <= i_in.id_in;
            r_q   <= IW'(w_qe_prod >> IW);
        end
        if (i_cmd.div_fix) begin
            r_q <= w_rem_ge ? IW'(r_q + 1'b1) : r_q;
            r_b <= w_rem_ge ? BW'(w_rem - (IW+1)'(NUM_BUCKETS)) : BW'(w_rem);
        end
        if (i_cmd.rd_fill) begin
            r_fill_vld <= r_vld[r_b];
        end
        if (i_cmd.slot_clr) begin
            r_slot <= '0;
        end else if (i_cmd.slot_inc) begin
            r_slot <= FW'(r_slot + 1'b1);
        end else if (i_cmd.rev_slot) begin
            r_slot <= FW'(r_q - 1'b1);
        end
        if (i_cmd.k_clr) begin
            r_k <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= LW'(r_k + 1'b1);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            case (i_cmd.res_sel)
                tdh_pkg::RES_HIT: begin
                    r_out.status      <= i_cmd.code;
                    r_out.id_out      <= tdh_pkg::ID_OUT_W'(w_hit_id);
                    r_out.out_char    <= '0;
                    r_out.last_result <= 1'b1;
                end
                tdh_pkg::RES_BYTE: begin
                    r_out.status      <= tdh_pkg::ST_OK;
                    r_out.id_out      <= tdh_pkg::ID_OUT_W'(r_id);
                    r_out.out_char    <= w_tok_q;
                    r_out.last_result <= w_k_last;
                end
                default: begin
                    r_out.status      <= i_cmd.code;
                    r_out.id_out      <= '0;
                    r_out.out_char    <= '0;
                    r_out.last_result <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Status to controller
    always_comb begin
        o_sts          = '0;
        o_sts.func_add = r_func_add;
        o_sts.ovl      = r_ovl;
        o_sts.fill_lt  = r_slot < w_fill_val;
        o_sts.full     = w_fill_val >= FW'(BUCKET_DEPTH);
        o_sts.len_eq   = w_len_q == r_alen;
        o_sts.byte_eq  = w_tok_q == w_asm_q;
        o_sts.k_last   = w_k_last;
        o_sts.rev_bad  = (r_q == '0) || (r_q > IW'(w_fill_val)) ||
                         (r_q > IW'(BUCKET_DEPTH));
        o_sts.rlen_bad = (w_len_q == '0) || (w_len_q > LW'(MAX_LEN));
        o_sts.out_free = w_out_free;
    end

    // Checks
    a_ld_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ld_out |-> w_out_free)
        else $error("result loaded over an untaken beat");
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_meta |-> (w_fill_val < FW'(BUCKET_DEPTH)))
        else $error("store into a full bucket");
    a_byte_rev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ld_out && (i_cmd.res_sel == tdh_pkg::RES_BYTE)) |-> r_rev)
        else $error("token byte emitted outside reverse lookup");
    a_ovl_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovl |-> (r_alen == LW'(MAX_LEN)))
        else $error("overlong flag with short assembly");

endmodule

FILE: design/tdh_ctrl.sv
// Controller: sequences hashing, bucket scan, store and reverse readout.
`timescale 1ns / 1ps

module tdh_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [tdh_pkg::FUNC_W-1:0]  i_func,
    input  logic                        i_last,
    input  tdh_pkg::t_sts               i_sts,
    output tdh_pkg::t_cmd               o_cmd,
    output logic                        o_in_ready
);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_BCHK    = 17'h00002,
        S_SCAN    = 17'h00004,
        S_LEN     = 17'h00008,
        S_CMP_RD  = 17'h00010,
        S_CMP_CHK = 17'h00020,
        S_COPY_RD = 17'h00040,
        S_COPY_WR = 17'h00080,
        S_META    = 17'h00100,
        S_RES     = 17'h00200,
        S_RDIV    = 17'h00400,
        S_RFILL   = 17'h00800,
        S_RCHK    = 17'h01000,
        S_RLEN    = 17'h02000,
        S_RLCHK   = 17'h04000,
        S_RRD     = 17'h08000,
        S_ROUT    = 17'h10000
    } t_state;

    t_state            r_state, n_state;
    tdh_pkg::t_status  r_code, n_code;
    tdh_pkg::t_res_sel r_sel, n_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= tdh_pkg::ST_OK;
            r_sel   <= tdh_pkg::RES_CODE;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_sel   <= n_sel;
        end
    end

    assign o_in_ready = r_state == S_IDLE;

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        n_code        = r_code;
        n_sel         = r_sel;
        o_cmd         = '0;
        o_cmd.res_sel = r_sel;
        o_cmd.code    = r_code;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == tdh_pkg::FUNC_REV) begin
                        o_cmd.take_id = 1'b1;
                        n_state       = S_RDIV;
                    end else if (i_func != tdh_pkg::FUNC_NOP) begin
                        o_cmd.take_byte = 1'b1;
                        if (i_last) begin
                            n_state = S_BCHK;
                        end
                    end
                end
            end
            S_BCHK: begin
                if (i_sts.ovl) begin
                    o_cmd.clr_asm = 1'b1;
                    n_code        = tdh_pkg::ST_TOO_LONG;
                    n_sel         = tdh_pkg::RES_CODE;
                    n_state       = S_RES;
                end else begin
                    o_cmd.rd_fill  = 1'b1;
                    o_cmd.slot_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.fill_lt) begin
                    o_cmd.rd_len = 1'b1;
                    n_state      = S_LEN;
                end else if (!i_sts.func_add) begin
                    o_cmd.clr_asm = 1'b1;
                    n_code        = tdh_pkg::ST_NOT_FOUND;
                    n_sel         = tdh_pkg::RES_CODE;
                    n_state       = S_RES;
                end else if (i_sts.full) begin
                    o_cmd.clr_asm = 1'b1;
                    n_code        = tdh_pkg::ST_FULL;
                    n_sel         = tdh_pkg::RES_CODE;
                    n_state       = S_RES;
                end else begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_COPY_RD;
                end
            end
            S_LEN: begin
                if (i_sts.len_eq) begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_CMP_RD;
                end else begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_CMP_RD: begin
                o_cmd.rd_tok = 1'b1;
                o_cmd.rd_asm = 1'b1;
                n_state      = S_CMP_CHK;
            end
            S_CMP_CHK: begin
                if (!i_sts.byte_eq) begin
                    o_cmd.slot_inc = 1'b1;
                    n_state        = S_SCAN;
                end else if (i_sts.k_last) begin
                    o_cmd.clr_asm = 1'b1;
                    n_code        = i_sts.func_add ? tdh_pkg::ST_DUP : tdh_pkg::ST_OK;
                    n_sel         = tdh_pkg::RES_HIT;
                    n_state       = S_RES;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_CMP_RD;
                end
            end
            S_COPY_RD: begin
                o_cmd.rd_asm = 1'b1;
                n_state      = S_COPY_WR;
            end
            S_COPY_WR: begin
                o_cmd.wr_tok = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_META;
                end else begin
                    o_cmd.k_inc = 1'b1;
                    n_state     = S_COPY_RD;
                end
            end
            S_META: begin
                o_cmd.wr_meta = 1'b1;
                o_cmd.clr_asm = 1'b1;
                n_code        = tdh_pkg::ST_OK;
                n_sel         = tdh_pkg::RES_HIT;
                n_state       = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RDIV: begin
                o_cmd.div_fix = 1'b1;
                n_state       = S_RFILL;
            end
            S_RFILL: begin
                o_cmd.rd_fill = 1'b1;
                n_state       = S_RCHK;
            end
            S_RCHK: begin
                if (i_sts.rev_bad) begin
                    n_code  = tdh_pkg::ST_NOT_FOUND;
                    n_sel   = tdh_pkg::RES_CODE;
                    n_state = S_RES;
                end else begin
                    o_cmd.rev_slot = 1'b1;
                    n_state        = S_RLEN;
                end
            end
            S_RLEN: begin
                o_cmd.rd_len = 1'b1;
                n_state      = S_RLCHK;
            end
            S_RLCHK: begin
                if (i_sts.rlen_bad) begin
                    n_code  = tdh_pkg::ST_NOT_FOUND;
                    n_sel   = tdh_pkg::RES_CODE;
                    n_state = S_RES;
                end else begin
                    o_cmd.k_clr = 1'b1;
                    n_state     = S_RRD;
                end
            end
            S_RRD: begin
                o_cmd.rd_tok = 1'b1;
                n_state      = S_ROUT;
            end
            S_ROUT: begin
                o_cmd.res_sel = tdh_pkg::RES_BYTE;
                if (i_sts.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    if (i_sts.k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state     = S_RRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/token_dictionary_hash_map.sv
// Top level of the token dictionary: controller plus datapath.
//
// Input channel (i_in_valid/o_in_ready, i_in_data): one beat per token byte
// for add (func 0) or lookup (func 1), last byte marked; or one beat with an
// id for reverse lookup (func 2). Func 3 beats are taken and dropped.
// Output channel (o_out_valid/i_out_ready, o_out_data): one beat per add or
// lookup or reverse miss; one per token byte of a reverse hit, last marked.
// A final token byte starts a scan of its bucket: a length read per entry,
// then a byte compare per byte where the length matches. An add that
// misses in a bucket with room copies the token in byte by byte and then
// writes the metadata. An overlong token skips the scan. A reverse
// lookup checks fill and length, then reads the token store once per byte.
// One request is in work at a time; input ready is low
// while it runs. Results sit in an output register, so a stalled receiver
// holds the finished beat while the block returns to idle; the next result
// waits until that beat is taken.
// Reset clears the bucket fill valid bits and the partial token at once; no
// clearing pass is needed and the block is ready straight out of reset.
`timescale 1ns / 1ps

module token_dictionary_hash_map #(
    parameter int NUM_BUCKETS  = tdh_pkg::NUM_BUCKETS_DEF,
    parameter int TOKEN_BYTES  = tdh_pkg::TOKEN_BYTES_DEF,
    parameter int BUCKET_DEPTH = tdh_pkg::BUCKET_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tdh_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tdh_pkg::t_out_beat o_out_data
);

    tdh_pkg::t_cmd w_cmd;
    tdh_pkg::t_sts w_sts;

    tdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .i_last     (i_in_data.last_char),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (o_in_ready)
    );

    tdh_datapath #(
        .NUM_BUCKETS  (NUM_BUCKETS),
        .TOKEN_BYTES  (TOKEN_BYTES),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out_data)
    );

endmodule

FILE: test/tdh_checker.sv
// Checker for the token dictionary: watches both channels, predicts results, compares.
`timescale 1ns / 1ps

module tdh_checker
    import tdh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int NB      = NUM_BUCKETS_DEF;
    localparam int MAXLEN  = TOKEN_BYTES_DEF - 1;
    localparam int DEPTH   = BUCKET_DEPTH_DEF;

    // Predictor state
    logic [7:0] part_bytes [MAXLEN];
    int         part_len;
    int         part_sum;
    bit         part_long;
    int         fill [NB];
    logic [7:0] dict_bytes [NB*DEPTH][MAXLEN];
    int         dict_len [NB*DEPTH];
    t_out_beat  expected_beats [$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_beats.size();

    function automatic t_out_beat make_beat(t_status st, int id, logic [7:0] ch, bit lst);
        t_out_beat r;
        r.status = st;
        r.id_out = id[ID_OUT_W-1:0];
        r.out_char = ch;
        r.last_result = lst;
        return r;
    endfunction

    // Find the assembled token in bucket b; -1 on miss
    function automatic int find_entry(int b);
        int e;
        bit same;
        for (int s = 0; s < fill[b] && s < DEPTH; s++) begin
            e = b * DEPTH + s;
            if (dict_len[e] == part_len) begin
                same = 1;
                for (int k = 0; k < part_len; k++)
                    if (dict_bytes[e][k] != part_bytes[k]) same = 0;
                if (same) return s;
            end
        end
        return -1;
    endfunction

    task automatic predict_beat(t_in_beat t);
        int b, q, e, s;
        if (t.func == FUNC_REV) begin
            b = t.id_in % NB;
            q = t.id_in / NB;
            if (q == 0 || q > fill[b] || q > DEPTH) begin
                expected_beats.push_back(make_beat(ST_NOT_FOUND, 0, 8'h00, 1'b1));
            end else begin
                e = b * DEPTH + q - 1;
                for (int k = 0; k < dict_len[e]; k++)
                    expected_beats.push_back(make_beat(ST_OK, t.id_in, dict_bytes[e][k],
                                                       k + 1 == dict_len[e]));
            end
            return;
        end
        if (t.func == FUNC_NOP) return;
        // Gather the byte, drop it past the maximum length
        if (part_len < MAXLEN) begin
            part_bytes[part_len] = t.token_char;
            part_len++;
        end else begin
            part_long = 1;
        end
        part_sum = (part_sum + t.token_char) % NB;
        if (!t.last_char) return;
        if (part_long) begin
            expected_beats.push_back(make_beat(ST_TOO_LONG, 0, 8'h00, 1'b1));
        end else begin
            b = part_sum;
            s = find_entry(b);
            if (t.func == FUNC_LOOKUP) begin
                if (s < 0) expected_beats.push_back(make_beat(ST_NOT_FOUND, 0, 8'h00, 1'b1));
                else expected_beats.push_back(make_beat(ST_OK, (s+1)*NB+b, 8'h00, 1'b1));
            end else if (s >= 0) begin
                expected_beats.push_back(make_beat(ST_DUP, (s+1)*NB+b, 8'h00, 1'b1));
            end else if (fill[b] >= DEPTH) begin
                expected_beats.push_back(make_beat(ST_FULL, 0, 8'h00, 1'b1));
            end else begin
                e = b * DEPTH + fill[b];
                for (int k = 0; k < part_len; k++) dict_bytes[e][k] = part_bytes[k];
                dict_len[e] = part_len;
                fill[b]++;
                expected_beats.push_back(make_beat(ST_OK, fill[b]*NB+b, 8'h00, 1'b1));
            end
        end
        part_len = 0;
        part_sum = 0;
        part_long = 0;
    endtask

    task automatic report_mismatch(string what, t_out_beat got, t_out_beat want);
        fail_count++;
        $display("mismatch %s: got st=%0d id=%0d ch=%0d last=%0d, %s%0d id=%0d ch=%0d last=%0d",
                 what, got.status, got.id_out, got.out_char, got.last_result,
                 "want st=", want.status, want.id_out, want.out_char, want.last_result);
    endtask

    // Predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            part_len = 0;
            part_sum = 0;
            part_long = 0;
            for (int i = 0; i < NB; i++) fill[i] = 0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat", i_out_data, '0);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_data !== want) report_mismatch("field", i_out_data, want);
                end
            end
            if (i_in_valid && i_in_ready) predict_beat(i_in_data);
        end
    end

endmodule

FILE: test/tb_token_dictionary_hash_map.sv
// Testbench top for the token dictionary: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_token_dictionary_hash_map;
    import tdh_pkg::*;

    localparam int NB         = NUM_BUCKETS_DEF;
    localparam int WATCH_MAX  = 20000;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_ready;
    t_in_beat  in_data = '0;
    logic      out_valid;
    logic      out_ready = 0;
    t_out_beat out_data;
    int        fail_count;
    int        pending;
    bit        calm = 0;
    bit        hold_off = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    int        known_ids [$];

    token_dictionary_hash_map u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    tdh_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // Send one beat, with a random idle burst before it unless calm
    task automatic send_beat(t_func f, logic [7:0] ch, bit lst, logic [15:0] id);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.func <= f;
        in_data.token_char <= ch;
        in_data.last_char <= lst;
        in_data.id_in <= id;
        do @(posedge clk); while (!in_ready);
    endtask

    // Send a whole token with the given request on its final byte
    task automatic send_token(t_func f, logic [7:0] bytes [], t_func mix_f);
        for (int k = 0; k < bytes.size(); k++)
            send_beat(k + 1 == bytes.size() ? f : mix_f, bytes[k], k + 1 == bytes.size(),
                      16'($urandom));
    endtask

    function automatic void random_token(ref logic [7:0] bytes [], input int len);
        bytes = new[len];
        foreach (bytes[k]) bytes[k] = 8'($urandom);
    endfunction

    // Receiver: random stall bursts, one long hold-off on request
    always @(posedge clk) begin
        if (!rst_n || hold_off) begin
            out_ready <= 1'b0;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 13);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering tokens
    initial begin
        wait (rst_n);
        repeat (200) @(posedge clk);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    initial begin
        logic [7:0] tok [];
        logic [7:0] stored [$][];
        int n, sel, len;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every request, duplicates, misses, overlong, nop
        tok = new[1]; tok[0] = 8'hFF;
        send_token(FUNC_ADD, tok, FUNC_ADD);
        send_token(FUNC_ADD, tok, FUNC_ADD);
        send_token(FUNC_LOOKUP, tok, FUNC_LOOKUP);
        send_beat(FUNC_REV, 8'h00, 1'b1, 16'd155);
        tok = new[1]; tok[0] = 8'h00;
        send_token(FUNC_LOOKUP, tok, FUNC_LOOKUP);
        send_token(FUNC_ADD, tok, FUNC_ADD);
        random_token(tok, 31);
        send_token(FUNC_ADD, tok, FUNC_LOOKUP);
        send_token(FUNC_LOOKUP, tok, FUNC_ADD);
        send_beat(FUNC_REV, 8'h00, 1'b1, 16'd0);
        send_beat(FUNC_REV, 8'h00, 1'b1, 16'hFFFF);
        send_beat(FUNC_REV, 8'hAA, 1'b0, 16'd100);
        random_token(tok, 33);
        send_token(FUNC_ADD, tok, FUNC_ADD);
        send_beat(FUNC_NOP, 8'h55, 1'b1, 16'h5555);
        // Reverse in the middle of an assembling token
        send_beat(FUNC_ADD, 8'h12, 1'b0, 16'd0);
        send_beat(FUNC_REV, 8'h00, 1'b0, 16'd100);
        send_beat(FUNC_ADD, 8'h34, 1'b1, 16'd0);

        // Fill one bucket past its depth with two-byte tokens summing to 207 (bucket 7)
        for (int i = 0; i < BUCKET_DEPTH_DEF + 2; i++) begin
            tok = new[2];
            tok[0] = 8'(i); tok[1] = 8'(207 - i);
            send_token(FUNC_ADD, tok, FUNC_ADD);
        end
        send_beat(FUNC_REV, 8'h00, 1'b1, 16'(BUCKET_DEPTH_DEF * NB + 7));
        send_beat(FUNC_REV, 8'h00, 1'b1, 16'((BUCKET_DEPTH_DEF + 1) * NB + 7));

        // Random: mostly short tokens, reuse of stored ones, reverse lookups
        for (int i = 0; i < 60; i++) begin
            if (i > 50) calm = 1;
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 34) : $urandom_range(1, 4);
                random_token(tok, len);
                send_token(FUNC_ADD, tok, t_func'($urandom_range(0, 1)));
                stored.push_back(tok);
            end else if (sel < 70 && stored.size() > 0) begin
                tok = stored[$urandom_range(0, stored.size() - 1)];
                send_token(t_func'($urandom_range(0, 1)), tok, t_func'($urandom_range(0, 1)));
            end else if (sel < 80) begin
                random_token(tok, $urandom_range(1, 3));
                send_token(FUNC_LOOKUP, tok, FUNC_LOOKUP);
            end else if (sel < 95) begin
                n = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4) * NB
                    + $urandom_range(0, NB - 1);
                send_beat(FUNC_REV, 8'($urandom), 1'($urandom), 16'(n));
            end else begin
                send_beat(FUNC_NOP, 8'($urandom), 1'($urandom), 16'($urandom));
            end
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
